// File: src/ovl_pkg.sv
// Shared types, codes and defaults for the ordered value list.
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

    // Default number of list entries
    localparam int unsigned DEPTH_DEF = 16;

    // Operation codes (high bit set selects a search)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // Command word
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] item_value;
    } cmd_word_t;

    // Result word
    typedef struct packed {
        logic [2:0] status;
        logic [4:0] entry_count;
    } res_word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TAIL,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: src/ordered_value_list.sv
// Bounded insertion-ordered list of signed 32-bit values held in one memory.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one command word:
//   insert at tail, delete a value, or search for a value (op high bit).
//   res channel (res_valid / res_stall / res) returns one result word per
//   command: a status code and the number of entries held afterwards.
//   A word moves on a rising edge with valid high and stall low.
//   Insert, and any command on an empty list, shows its result the cycle
//   after acceptance. A search walks the entries from the head, one memory
//   read per cycle. A delete reads the tail, then the head; it drops the
//   tail if the tail matches and the head does not, else scans to the first
//   match and closes the gap with one read and one write per cycle.
//   The single read port of the entry memory sets this pace.
//   One command is worked on at a time; cmd_stall is high while a command
//   is in progress or while a held result is stalled, so the next command
//   can be taken in the cycle the result shows, unless it is stalled
//   (inserts: every cycle while results are not stalled). Reset empties
//   the list at once (no clearing pass); entries are only read below the
//   held count. A stalled result holds unchanged in the output register until taken.
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list #(
    parameter int unsigned DEPTH = ovl_pkg::DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire ovl_pkg::cmd_word_t cmd,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output ovl_pkg::res_word_t     res
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Entry memory
    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Control and payload registers
    ovl_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [31:0]        key_reg, key_next;
    logic               del_reg, del_next;
    logic               tail_hit_reg, tail_hit_next;
    logic [2:0]         status_reg, status_next;
    logic               res_valid_reg, res_valid_next;
    ovl_pkg::res_word_t res_reg, res_next;

    logic          accept;
    logic          out_free;
    logic          hit;
    logic          at_last;
    logic [CW-1:0] count_dec;

    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ovl_pkg::S_IDLE) || (res_valid_reg && res_stall);
    assign hit       = (rd_data_reg == key_reg);
    assign count_dec = count_reg - 1'b1;
    assign at_last   = (CW'(idx_reg) == count_dec);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ovl_pkg::S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        del_reg      <= del_next;
        tail_hit_reg <= tail_hit_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
    end

    // Sequence one command: decode, scan, compact, report
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        del_next       = del_reg;
        tail_hit_next  = tail_hit_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(count_reg);
        mem_wdata      = key_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;

        unique case (state_reg)
            ovl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next = cmd.item_value;
                    del_next = (cmd.op == ovl_pkg::OP_DELETE);
                    idx_next = '0;
                    if (cmd.op == ovl_pkg::OP_INSERT)
                    begin
                        // Append at tail or refuse when full
                        res_valid_next = 1'b1;
                        if (count_reg >= CW'(DEPTH))
                        begin
                            res_next.status      = ovl_pkg::ST_FULL;
                            res_next.entry_count = 5'(count_reg);
                        end
                        else
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = AW'(count_reg);
                            mem_wdata            = cmd.item_value;
                            count_next           = count_reg + 1'b1;
                            res_next.status      = ovl_pkg::ST_INSERTED;
                            res_next.entry_count = 5'(count_reg + 1'b1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.status      = ovl_pkg::ST_EMPTY;
                        res_next.entry_count = 5'(count_reg);
                    end
                    else if (cmd.op == ovl_pkg::OP_DELETE)
                    begin
                        // Fetch the tail first
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(count_dec);
                        state_next = ovl_pkg::S_TAIL;
                    end
                    else
                    begin
                        // Search starts at the head
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = ovl_pkg::S_SCAN;
                    end
                end
            end

            ovl_pkg::S_TAIL:
            begin
                tail_hit_next = hit;
                mem_re        = 1'b1;
                mem_raddr     = '0;
                idx_next      = '0;
                state_next    = ovl_pkg::S_SCAN;
            end

            ovl_pkg::S_SCAN:
            begin
                if (!del_reg)
                begin
                    if (hit)
                    begin
                        status_next = ovl_pkg::ST_FOUND;
                        state_next  = ovl_pkg::S_DONE;
                    end
                    else if (at_last)
                    begin
                        status_next = ovl_pkg::ST_NOT_FOUND;
                        state_next  = ovl_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + 1'b1;
                    end
                end
                else if (hit && (idx_reg == '0 || !tail_hit_reg))
                begin
                    // Remove this entry; shift the rest down
                    status_next = ovl_pkg::ST_DELETED;
                    if (at_last)
                    begin
                        count_next = count_dec;
                        state_next = ovl_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        mem_re     = 1'b1;
                        mem_raddr  = idx_reg + 1'b1;
                        state_next = ovl_pkg::S_SHIFT;
                    end
                end
                else if (tail_hit_reg)
                begin
                    // Drop the tail
                    status_next = ovl_pkg::ST_DELETED;
                    count_next  = count_dec;
                    state_next  = ovl_pkg::S_DONE;
                end
                else if (at_last)
                begin
                    status_next = ovl_pkg::ST_NOT_FOUND;
                    state_next  = ovl_pkg::S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                end
            end

            ovl_pkg::S_SHIFT:
            begin
                // Move entry idx down one place
                mem_we    = 1'b1;
                mem_waddr = idx_reg - 1'b1;
                mem_wdata = rd_data_reg;
                if (at_last)
                begin
                    count_next = count_dec;
                    state_next = ovl_pkg::S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                end
            end

            ovl_pkg::S_DONE:
            begin
                // Hold the result until the output register frees
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.status      = status_reg;
                    res_next.entry_count = 5'(count_reg);
                    state_next           = ovl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ovl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/ovl_checker.sv
// Port-level checks for the ordered value list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ovl_checker #(
    parameter int unsigned DEPTH = ovl_pkg::DEPTH_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_stall,
    input wire ovl_pkg::cmd_word_t cmd,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire ovl_pkg::res_word_t res
);

    // A stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.status <= ovl_pkg::ST_FULL))
        else $error("undefined status code");

    // A full refusal reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ovl_pkg::ST_FULL |-> res.entry_count == 5'(DEPTH))
        else $error("full status with wrong count");

    // An empty report carries no entries
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ovl_pkg::ST_EMPTY |-> res.entry_count == 5'd0)
        else $error("empty status with nonzero count");

    // An accepted insert answers on the next cycle
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.op == ovl_pkg::OP_INSERT |=> res_valid)
        else $error("insert result missing");

endmodule

bind ordered_value_list ovl_checker #(.DEPTH(DEPTH)) u_ovl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
